@@ rtl/gnta_pkg.sv @@
package gnta_pkg;

  localparam int unsigned GateBits = 26;
  localparam int unsigned MissCfgBits = 3;
  localparam int unsigned CfgDataBits = 26;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned KindBits = 3;
  localparam int unsigned OutIdBits = 16;
  localparam int unsigned MissBits = 4;

  localparam logic [CfgIdxBits-1:0] CfgGate = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgMaxMissed = 1'd1;

  localparam logic [GateBits-1:0] GateReset = 26'd1000;
  localparam logic [MissCfgBits-1:0] MaxMissedReset = 3'd3;
  localparam logic [MissBits-1:0] MissSat = 4'd15;

  localparam logic [KindBits-1:0] ResMatched = 3'd0;
  localparam logic [KindBits-1:0] ResCreated = 3'd1;
  localparam logic [KindBits-1:0] ResDropped = 3'd2;
  localparam logic [KindBits-1:0] ResDeleted = 3'd3;
  localparam logic [KindBits-1:0] ResFrameDone = 3'd4;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;     // capture the detection, clear the search
    logic scan;     // evaluate the slot at the scan index
    logic commit;   // apply match or create
    logic age;      // age the slot at the scan index
    logic purge;    // test/free the slot at the scan index
  } dp_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic purge_hit;   // slot at the scan index is being deleted
  } dp_sts_t;

endpackage

@@ rtl/gnta_if.sv @@
interface gnta_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] detection_x;
  logic [COORD_BITS-1:0] detection_y;
  modport source (output valid, kind, detection_x, detection_y, input ready);
  modport sink (input valid, kind, detection_x, detection_y, output ready);
endinterface

interface gnta_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] track_ident;
  logic        is_last;
  modport source (output valid, result_kind, track_ident, is_last, input ready);
  modport sink (input valid, result_kind, track_ident, is_last, output ready);
endinterface

@@ rtl/gnta_datapath.sv @@
module gnta_datapath #(
  parameter int unsigned MAX_TRACKS = 16,
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ID_BITS = 16,
  localparam int unsigned SlotBits = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gnta_pkg::dp_cmd_t                  cmd_i,
  input  logic [SlotBits-1:0]                slot_i,
  input  logic [COORD_BITS-1:0]              det_x_i,
  input  logic [COORD_BITS-1:0]              det_y_i,
  input  logic [gnta_pkg::GateBits-1:0]      gate_i,
  input  logic [gnta_pkg::MissCfgBits-1:0]   max_missed_i,
  output gnta_pkg::dp_sts_t                  sts_o,
  output logic [gnta_pkg::KindBits-1:0]      det_kind_o,
  output logic [gnta_pkg::OutIdBits-1:0]     det_id_o,
  output logic [gnta_pkg::OutIdBits-1:0]     slot_id_o
);
  import gnta_pkg::*;

  localparam int unsigned DistBits = 2 * COORD_BITS + 1;
  localparam int unsigned CmpBits = (DistBits > GateBits) ? DistBits : GateBits;

  logic [COORD_BITS-1:0] pos_x_q [MAX_TRACKS];
  logic [COORD_BITS-1:0] pos_y_q [MAX_TRACKS];
  logic [ID_BITS-1:0]    ident_q [MAX_TRACKS];
  logic [MissBits-1:0]   miss_q  [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] matched_q, valid_q;
  logic [ID_BITS-1:0]    next_id_q;

  logic [COORD_BITS-1:0] qx_q, qy_q;
  logic                  best_ok_q, free_ok_q;
  logic [SlotBits-1:0]   best_q, free_q;
  logic [DistBits-1:0]   best_d_q;

  logic [COORD_BITS-1:0] dx, dy;
  logic [DistBits-1:0]   sq_dist;
  logic                  hit_match;
  logic [MissBits-1:0]   aged;

  // Squared distance of the scanned slot.
  always_comb begin
    dx = (qx_q >= pos_x_q[slot_i]) ? qx_q - pos_x_q[slot_i] : pos_x_q[slot_i] - qx_q;
    dy = (qy_q >= pos_y_q[slot_i]) ? qy_q - pos_y_q[slot_i] : pos_y_q[slot_i] - qy_q;
    sq_dist = (DistBits'(dx) * DistBits'(dx)) + (DistBits'(dy) * DistBits'(dy));
  end

  assign hit_match = best_ok_q && (CmpBits'(best_d_q) < CmpBits'(gate_i));
  assign aged = matched_q[slot_i] ? '0 :
                (miss_q[slot_i] < MissSat) ? miss_q[slot_i] + 1'b1 : miss_q[slot_i];
  assign sts_o.purge_hit = valid_q[slot_i] &&
                           (miss_q[slot_i] > MissBits'(max_missed_i));

  // Detection result, valid once the scan is done; sampled with the commit.
  always_comb begin
    if (hit_match) begin
      det_kind_o = ResMatched;
      det_id_o   = OutIdBits'(ident_q[best_q]);
    end else if (free_ok_q) begin
      det_kind_o = ResCreated;
      det_id_o   = OutIdBits'(next_id_q);
    end else begin
      det_kind_o = ResDropped;
      det_id_o   = '0;
    end
  end
  assign slot_id_o = OutIdBits'(ident_q[slot_i]);

  // Search registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qx_q <= det_x_i;
      qy_q <= det_y_i;
    end
    if (cmd_i.scan && valid_q[slot_i] && !matched_q[slot_i] &&
        (!best_ok_q || sq_dist < best_d_q)) begin
      best_q   <= slot_i;
      best_d_q <= sq_dist;
    end
    if (cmd_i.scan && !valid_q[slot_i] && !free_ok_q) free_q <= slot_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_ok_q <= 1'b0;
      free_ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      best_ok_q <= 1'b0;
      free_ok_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (valid_q[slot_i] && !matched_q[slot_i]) best_ok_q <= 1'b1;
      if (!valid_q[slot_i]) free_ok_q <= 1'b1;
    end
  end

  // Track table payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (hit_match) begin
        pos_x_q[best_q] <= qx_q;
        pos_y_q[best_q] <= qy_q;
        miss_q[best_q]  <= '0;
      end else if (free_ok_q) begin
        pos_x_q[free_q] <= qx_q;
        pos_y_q[free_q] <= qy_q;
        miss_q[free_q]  <= '0;
        ident_q[free_q] <= next_id_q;
      end
    end
    if (cmd_i.age && valid_q[slot_i]) miss_q[slot_i] <= aged;
  end

  // Track table control bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= '0;
      valid_q   <= '0;
      next_id_q <= '0;
    end else begin
      if (cmd_i.commit) begin
        if (hit_match) begin
          matched_q[best_q] <= 1'b1;
        end else if (free_ok_q) begin
          matched_q[free_q] <= 1'b1;
          valid_q[free_q]   <= 1'b1;
          next_id_q         <= next_id_q + 1'b1;
        end
      end
      if (cmd_i.age) matched_q[slot_i] <= 1'b0;
      if (cmd_i.purge && sts_o.purge_hit) valid_q[slot_i] <= 1'b0;
    end
  end

endmodule

@@ rtl/gnta_ctrl.sv @@
module gnta_ctrl #(
  parameter int unsigned MAX_TRACKS = 16,
  localparam int unsigned SlotBits = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_kind_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gnta_pkg::dp_cmd_t               cmd_o,
  input  gnta_pkg::dp_sts_t               sts_i,
  output logic [SlotBits-1:0]             slot_o,
  input  logic [gnta_pkg::KindBits-1:0]   det_kind_i,
  input  logic [gnta_pkg::OutIdBits-1:0]  det_id_i,
  input  logic [gnta_pkg::OutIdBits-1:0]  slot_id_i,
  output logic [gnta_pkg::KindBits-1:0]   res_kind_o,
  output logic [gnta_pkg::OutIdBits-1:0]  res_id_o,
  output logic                            res_last_o
);
  import gnta_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StCommit = 3'd2;
  localparam logic [2:0] StAge    = 3'd3;
  localparam logic [2:0] StPurge  = 3'd4;
  localparam logic [2:0] StOut    = 3'd5;

  localparam logic [SlotBits-1:0] LastSlot = SlotBits'(MAX_TRACKS - 1);

  logic [2:0]          state_q, state_d;
  logic [SlotBits-1:0] slot_q, slot_d;
  logic                purge_more_q, purge_more_d;
  logic [KindBits-1:0] kind_q, kind_d;
  logic [OutIdBits-1:0] id_q, id_d;
  logic                last_q, last_d;
  logic                accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign slot_o      = slot_q;
  assign res_kind_o  = kind_q;
  assign res_id_o    = id_q;
  assign res_last_o  = last_q;

  // Sequence scan, commit, aging and purge.
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    purge_more_d = purge_more_q;
    kind_d       = kind_q;
    id_d         = id_q;
    last_d       = last_q;
    cmd_o        = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          slot_d     = '0;
          cmd_o.load = !in_kind_i;
          state_d    = in_kind_i ? StAge : StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        slot_d     = slot_q + 1'b1;
        if (slot_q == LastSlot) state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        kind_d       = det_kind_i;
        id_d         = det_id_i;
        last_d       = 1'b1;
        state_d      = StOut;
      end
      StAge: begin
        cmd_o.age = 1'b1;
        if (slot_q == LastSlot) begin
          state_d = StPurge;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      StPurge: begin
        cmd_o.purge = 1'b1;
        if (sts_i.purge_hit) begin
          kind_d       = ResDeleted;
          id_d         = slot_id_i;
          last_d       = 1'b0;
          purge_more_d = (slot_q != '0);
          state_d      = StOut;
        end else if (slot_q == '0) begin
          kind_d       = ResFrameDone;
          id_d         = '0;
          last_d       = 1'b1;
          purge_more_d = 1'b0;
          state_d      = StOut;
        end
        if (slot_q != '0) slot_d = slot_q - 1'b1;
      end
      StOut: begin
        if (out_ready_i) begin
          if (last_q) begin
            state_d = StIdle;
          end else if (purge_more_q) begin
            state_d = StPurge;
          end else begin
            kind_d  = ResFrameDone;
            id_d    = '0;
            last_d  = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      slot_q       <= '0;
      purge_more_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_q       <= slot_d;
      purge_more_q <= purge_more_d;
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    id_q   <= id_d;
  end

endmodule

@@ rtl/greedy_nearest_track_associator.sv @@
// Greedy nearest-neighbor track associator.
// Detection: an accept, a scan of every slot and a commit, then one result beat.
// End of frame: aging of every slot, then a descending purge of one slot per cycle,
// each deletion beat waiting on the sink, then a frame-done beat.
// One item at a time; the slot scan sets the rate.
// Reset (async, active low) clears the valid and matched bits, id counter and configuration registers.
module greedy_nearest_track_associator #(
  parameter int unsigned MAX_TRACKS = 16,
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gnta_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [gnta_pkg::CfgDataBits-1:0]      cfg_data_i,
  gnta_in_if.sink                               in_if,
  gnta_out_if.source                            out_if
);
  import gnta_pkg::*;

  localparam int unsigned SlotBits = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  logic [GateBits-1:0]    gate_q;
  logic [MissCfgBits-1:0] max_missed_q;
  dp_cmd_t                cmd;
  dp_sts_t                sts;
  logic [SlotBits-1:0]    slot;
  logic [KindBits-1:0]    det_kind;
  logic [OutIdBits-1:0]   det_id, slot_id;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q       <= GateReset;
      max_missed_q <= MaxMissedReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGate:      gate_q <= cfg_data_i[GateBits-1:0];
        CfgMaxMissed: max_missed_q <= cfg_data_i[MissCfgBits-1:0];
        default: ;
      endcase
    end
  end

  gnta_ctrl #(.MAX_TRACKS(MAX_TRACKS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_kind_i   (in_if.kind),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .slot_o      (slot),
    .det_kind_i  (det_kind),
    .det_id_i    (det_id),
    .slot_id_i   (slot_id),
    .res_kind_o  (out_if.result_kind),
    .res_id_o    (out_if.track_ident),
    .res_last_o  (out_if.is_last)
  );

  gnta_datapath #(
    .MAX_TRACKS(MAX_TRACKS), .COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .slot_i       (slot),
    .det_x_i      (in_if.detection_x),
    .det_y_i      (in_if.detection_y),
    .gate_i       (gate_q),
    .max_missed_i (max_missed_q),
    .sts_o        (sts),
    .det_kind_o   (det_kind),
    .det_id_o     (det_id),
    .slot_id_o    (slot_id)
  );

endmodule

@@ test/gnta_scoreboard.sv @@
`timescale 1ns / 100ps

// Watch the detection and result channels, track the association table and
// compare every result beat against the predicted one.
module gnta_scoreboard #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gnta_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [gnta_pkg::CfgDataBits-1:0] cfg_data_i,
  gnta_in_if                               det_mon,
  gnta_out_if                              res_mon,
  output int                               errors_o,
  output int                               pending_o
);
  import gnta_pkg::*;

  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic [OutIdBits-1:0] ident;
    logic                 last;
  } beat_t;

  typedef struct packed {
    logic                 live;
    logic                 hit;
    logic [11:0]          x;
    logic [11:0]          y;
    logic [15:0]          ident;
    logic [MissBits-1:0]  misses;
  } track_t;

  track_t               tracks[SLOTS];
  logic [15:0]          id_counter;
  logic [GateBits-1:0]  gate;
  logic [MissCfgBits-1:0] miss_limit;
  beat_t                awaited[$];
  int                   errors;
  int                   pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic logic [25:0] dist_sq(logic [11:0] ax, logic [11:0] ay,
                                          logic [11:0] bx, logic [11:0] by);
    logic [12:0] dx;
    logic [12:0] dy;
    dx = (ax >= bx) ? 13'(ax - bx) : 13'(bx - ax);
    dy = (ay >= by) ? 13'(ay - by) : 13'(by - ay);
    return (26'(dx) * 26'(dx)) + (26'(dy) * 26'(dy));
  endfunction

  // Queue one predicted beat at the tail.
  task automatic queue_beat(logic [KindBits-1:0] kind, logic [OutIdBits-1:0] ident,
                            logic last);
    beat_t b;
    b = '{kind, ident, last};
    awaited.insert(awaited.size(), b);
  endtask

  // Pair a detection with the nearest unmatched track within the gate, or open or drop one.
  task automatic associate(logic [11:0] qx, logic [11:0] qy);
    int best;
    int open_slot;
    logic [25:0] best_d;
    logic [25:0] d;
    best = -1;
    open_slot = -1;
    best_d = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tracks[i].live) begin
        if (open_slot < 0) open_slot = i;
      end else if (!tracks[i].hit) begin
        d = dist_sq(qx, qy, tracks[i].x, tracks[i].y);
        if (best < 0 || d < best_d) begin
          best = i;
          best_d = d;
        end
      end
    end
    if (best >= 0 && best_d < gate) begin
      tracks[best].x = qx;
      tracks[best].y = qy;
      tracks[best].misses = '0;
      tracks[best].hit = 1'b1;
      queue_beat(ResMatched, tracks[best].ident, 1'b1);
    end else if (open_slot >= 0) begin
      tracks[open_slot] = '{1'b1, 1'b1, qx, qy, id_counter, '0};
      id_counter = id_counter + 16'd1;
      queue_beat(ResCreated, tracks[open_slot].ident, 1'b1);
    end else begin
      queue_beat(ResDropped, 16'd0, 1'b1);
    end
  endtask

  // Age every track, free the stale ones from the top slot down.
  task automatic close_frame();
    for (int i = 0; i < SLOTS; i++) begin
      if (tracks[i].live) begin
        if (tracks[i].hit) tracks[i].misses = '0;
        else if (tracks[i].misses != MissSat) tracks[i].misses = tracks[i].misses + 1'b1;
      end
      tracks[i].hit = 1'b0;
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (tracks[i].live && tracks[i].misses > {1'b0, miss_limit}) begin
        tracks[i].live = 1'b0;
        queue_beat(ResDeleted, tracks[i].ident, 1'b0);
      end
    end
    queue_beat(ResFrameDone, 16'd0, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t got;
    beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) tracks[i] = '0;
      id_counter = '0;
      gate = GateReset;
      miss_limit = MaxMissedReset;
      awaited.delete();
      errors = 0;
      pending = 0;
    end else begin
      // Latch register writes.
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgGate) gate = cfg_data_i[GateBits-1:0];
        else if (cfg_idx_i == CfgMaxMissed) miss_limit = cfg_data_i[MissCfgBits-1:0];
      end
      // Predict on each detection beat.
      if (det_mon.valid && det_mon.ready) begin
        if (det_mon.kind) close_frame();
        else associate(det_mon.detection_x, det_mon.detection_y);
      end
      // Compare each result beat with the oldest prediction.
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.result_kind, res_mon.track_ident, res_mon.is_last};
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat kind=%0d id=%0d last=%0d",
                   $time, got.kind, got.ident, got.last);
        end else begin
          want = awaited.pop_front();
          if (got.kind !== want.kind) begin
            errors++;
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
          end
          if (got.ident !== want.ident) begin
            errors++;
            $display("%0t: track_ident expected %0d actual %0d", $time, want.ident, got.ident);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: is_last expected %0d actual %0d", $time, want.last, got.last);
          end
        end
      end
      pending = awaited.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import gnta_pkg::*;

  localparam int StallLimit = 3000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  int                     errors;
  int                     pending;
  int                     quiet_cycles;
  bit                     calm;
  int                     hold_left;
  logic [11:0]            centers_x[24];
  logic [11:0]            centers_y[24];

  gnta_in_if #(.COORD_BITS(12)) det_ch ();
  gnta_out_if                   res_ch ();

  greedy_nearest_track_associator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (det_ch),
    .out_if     (res_ch)
  );

  gnta_scoreboard u_scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .det_mon    (det_ch),
    .res_mon    (res_ch),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side in random bursts until the calm tail.
  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (!calm) begin
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 18);
        rdy = 1'b0;
      end
    end
    res_ch.ready <= rdy;
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((det_ch.valid && det_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk_i);
      det_ch.valid <= 1'b0;
    end
  endtask

  // Present one beat and hold it until taken.
  task automatic send(logic kind, logic [11:0] x, logic [11:0] y);
    if (!calm && $urandom_range(0, 4) == 0) idle($urandom_range(1, 19));
    @(negedge clk_i);
    det_ch.valid       <= 1'b1;
    det_ch.kind        <= kind;
    det_ch.detection_x <= x;
    det_ch.detection_y <= y;
    // Ready is stable between edges: wait for it at a falling edge, then pass the edge.
    while (!det_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    idle(1);
    while (pending != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [11:0] jitter(logic [11:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 40) - 20;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Mostly detections near a set of moving targets, some noise, some frame ends.
  task automatic random_frames(int n);
    int pick;
    for (int i = 0; i < 24; i++) begin
      centers_x[i] = 12'($urandom);
      centers_y[i] = 12'($urandom);
    end
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send(1'b1, 12'($urandom), 12'($urandom));
      end else if (pick < 75) begin
        pick = $urandom_range(0, 23);
        centers_x[pick] = jitter(centers_x[pick]);
        centers_y[pick] = jitter(centers_y[pick]);
        send(1'b0, centers_x[pick], centers_y[pick]);
      end else begin
        send(1'b0, 12'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    calm = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgGate;
    cfg_data_i = '0;
    det_ch.valid = 1'b0;
    det_ch.kind = 1'b0;
    det_ch.detection_x = '0;
    det_ch.detection_y = '0;
    res_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Corners, a track made and matched at once, and a full table.
    send(1'b0, 12'd0, 12'd0);
    send(1'b0, 12'd4095, 12'd4095);
    send(1'b0, 12'd0, 12'd0);
    send(1'b1, 12'd0, 12'd0);
    send(1'b0, 12'd10, 12'd10);
    for (int k = 0; k < 13; k++) send(1'b0, 12'(300 * k + 200), 12'd2000);
    send(1'b0, 12'd2048, 12'd3500);
    send(1'b1, 12'd4095, 12'd4095);
    drain();

    // Sweep the register extremes, then random settings.
    write_reg(CfgGate, 26'd0);
    write_reg(CfgMaxMissed, 26'd0);
    random_frames(110);
    drain();
    write_reg(CfgGate, 26'h3FFFFFF);
    write_reg(CfgMaxMissed, 26'd7);
    random_frames(110);
    drain();
    write_reg(CfgGate, 26'd1000);
    write_reg(CfgMaxMissed, 26'd3);
    random_frames(110);
    drain();
    write_reg(CfgGate, 26'($urandom_range(0, 4000)));
    write_reg(CfgMaxMissed, 26'($urandom_range(0, 7)));
    random_frames(70);
    calm = 1'b1;
    random_frames(60);

    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
